### rtl/core/mlr_pkg.sv
// Shared types, codes and constants of the matrix line rotator.
package mlr_pkg;

  localparam int MAX_DIM_DEF    = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_FLD_W = 5;
  localparam int AMT_W     = 10;
  localparam int WORD_W    = 32;

  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 6'd32;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ROT_ROW = 2'd2,
    OP_ROT_COL = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        opcode;
    logic [IDX_FLD_W-1:0]       row_index;
    logic [IDX_FLD_W-1:0]       col_index;
    logic                       direction;
    logic [AMT_W-1:0]           amount;
    logic signed [WORD_W-1:0]   write_data;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   read_data;
    logic                       status;
  } out_item_t;

endpackage

### rtl/core/mlr_rem.sv
// Bit-serial restoring remainder unit: rotation amount modulo line length.
module mlr_rem #(
  parameter int LEN_W = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mlr_pkg::AMT_W-1:0] dividend,
  input  logic [LEN_W-1:0]         divisor,
  output logic                     done,
  output logic [LEN_W-1:0]         remainder
);

  localparam int STEP_W = $clog2(mlr_pkg::AMT_W + 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [mlr_pkg::AMT_W-1:0] quo_r, quo_nxt;
  logic [LEN_W-1:0]          rem_r, rem_nxt;
  logic [LEN_W-1:0]          div_r, div_nxt;
  logic [LEN_W:0]            trial;

  assign trial = {rem_r, quo_r[mlr_pkg::AMT_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(mlr_pkg::AMT_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = LEN_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = LEN_W'(trial);
      end
      quo_nxt  = quo_r << 1;
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### rtl/core/matrix_line_rotator_core.sv
// Matrix line rotator: element store, line buffer and operation sequencer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------
//   cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//   in      | in        | in_valid/in_stall  | in_data (in_item_t)
//   out     | out       | out_valid/out_stall| out_data (out_item_t)
//
// Writes, reads, flagged items and rotations of an empty line need no line
// pass. Every other rotation first runs the 10-step remainder unit and, unless
// the amount is a whole number of line lengths, makes one pass of the line
// to the line buffer and one pass back through the single read and write port
// of the element store. One item at a time; a finished result waits in the
// output register while the next transaction is accepted.
// Reset is synchronous, active low; it clears control state and sets both
// size registers to 32. Store contents stay undefined until written.
module matrix_line_rotator_core #(
  parameter int MAX_DIM    = mlr_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mlr_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mlr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mlr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mlr_pkg::out_item_t            out_data
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int LEN_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int CMP_W  = (LEN_W > mlr_pkg::CFG_W) ? LEN_W : mlr_pkg::CFG_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_READ  = 7'b0000100,
    S_REM   = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_STORE = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mlr_pkg::CFG_W-1:0]  num_rows_r, num_rows_nxt;
  logic [mlr_pkg::CFG_W-1:0]  num_cols_r, num_cols_nxt;
  mlr_pkg::in_item_t          item_r, item_nxt;
  mlr_pkg::out_item_t         res_r, res_nxt;
  mlr_pkg::out_item_t         out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [LEN_W-1:0]           cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]          base_r, base_nxt;
  logic [ADDR_W-1:0]          addr_r, addr_nxt;
  logic [IDX_W-1:0]           dst_r, dst_nxt;
  logic                       col_mode_r, col_mode_nxt;
  logic                       p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]           p_dst_r, p_dst_nxt;
  logic [ADDR_W-1:0]          p_addr_r, p_addr_nxt;

  logic [DATA_WIDTH-1:0] mat_mem [MAX_DIM*MAX_DIM];
  logic [DATA_WIDTH-1:0] buf_mem [MAX_DIM];
  logic [DATA_WIDTH-1:0] mat_rdata_r;
  logic [DATA_WIDTH-1:0] buf_rdata_r;

  logic                  mat_we;
  logic [ADDR_W-1:0]     mat_waddr;
  logic [DATA_WIDTH-1:0] mat_wdata;
  logic [ADDR_W-1:0]     mat_raddr;
  logic                  buf_we;

  logic [CMP_W-1:0]      rows_ext, cols_ext, max_ext;
  logic [LEN_W-1:0]      rows_used, cols_used;
  logic                  row_ok, col_ok;
  logic [ADDR_W-1:0]     row_base, elem_addr, stride;
  logic signed [mlr_pkg::WORD_W-1:0] wdata_s;
  logic                  out_free;
  logic                  rem_start, rem_done;
  logic [LEN_W-1:0]      rem_val, dst_start;
  logic                  dst_last;

  assign rows_ext  = CMP_W'(num_rows_r);
  assign cols_ext  = CMP_W'(num_cols_r);
  assign max_ext   = CMP_W'(MAX_DIM);
  assign rows_used = LEN_W'((rows_ext > max_ext) ? max_ext : rows_ext);
  assign cols_used = LEN_W'((cols_ext > max_ext) ? max_ext : cols_ext);
  assign row_ok    = CMP_W'(item_r.row_index) < CMP_W'(rows_used);
  assign col_ok    = CMP_W'(item_r.col_index) < CMP_W'(cols_used);
  assign row_base  = ADDR_W'(ADDR_W'(item_r.row_index) * ADDR_W'(MAX_DIM));
  assign elem_addr = row_base + ADDR_W'(item_r.col_index);
  assign stride    = col_mode_r ? ADDR_W'(MAX_DIM) : ADDR_W'(1);
  assign wdata_s   = item_r.write_data;
  assign out_free  = !out_valid_r || !out_stall;
  assign dst_start = item_r.direction ? rem_val : (len_r - rem_val);
  assign dst_last  = (LEN_W'(dst_r) == (len_r - LEN_W'(1)));
  assign buf_we    = p_vld_r && (state_r == S_LOAD);

  mlr_rem #(
    .LEN_W (LEN_W)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (item_r.amount),
    .divisor   (len_nxt),
    .done      (rem_done),
    .remainder (rem_val)
  );

  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    if (cfg_we) begin
      case (mlr_pkg::cfg_reg_t'(cfg_index))
        mlr_pkg::REG_NUM_ROWS: num_rows_nxt = cfg_wdata;
        mlr_pkg::REG_NUM_COLS: num_cols_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    res_nxt      = res_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    base_nxt     = base_r;
    addr_nxt     = addr_r;
    dst_nxt      = dst_r;
    col_mode_nxt = col_mode_r;
    p_vld_nxt    = 1'b0;
    p_dst_nxt    = p_dst_r;
    p_addr_nxt   = p_addr_r;
    rem_start    = 1'b0;
    mat_we       = 1'b0;
    mat_waddr    = p_addr_r;
    mat_wdata    = buf_rdata_r;
    mat_raddr    = addr_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_nxt.read_data = '0;
        res_nxt.status    = 1'b0;
        state_nxt         = S_FIN;
        case (item_r.opcode)
          mlr_pkg::OP_WRITE: begin
            if (row_ok && col_ok) begin
              mat_we    = 1'b1;
              mat_waddr = elem_addr;
              mat_wdata = DATA_WIDTH'(wdata_s);
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          mlr_pkg::OP_READ: begin
            if (row_ok && col_ok) begin
              mat_raddr = elem_addr;
              state_nxt = S_READ;
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          mlr_pkg::OP_ROT_ROW: begin
            len_nxt      = cols_used;
            base_nxt     = row_base;
            col_mode_nxt = 1'b0;
            if (!row_ok) begin
              res_nxt.status = 1'b1;
            end else if (cols_used != '0) begin
              state_nxt = S_REM;
            end
          end
          default: begin
            len_nxt      = rows_used;
            base_nxt     = ADDR_W'(item_r.col_index);
            col_mode_nxt = 1'b1;
            if (!col_ok) begin
              res_nxt.status = 1'b1;
            end else if (rows_used != '0) begin
              state_nxt = S_REM;
            end
          end
        endcase
      end

      S_READ: begin
        res_nxt.read_data = mlr_pkg::WORD_W'(mat_rdata_r);
        state_nxt         = S_FIN;
      end

      S_REM: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            state_nxt = S_FIN;
          end else begin
            cnt_nxt   = '0;
            addr_nxt  = base_r;
            dst_nxt   = dst_start[IDX_W-1:0];
            state_nxt = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        if (cnt_r < len_r) begin
          p_vld_nxt = 1'b1;
          p_dst_nxt = dst_r;
          cnt_nxt   = cnt_r + LEN_W'(1);
          addr_nxt  = addr_r + stride;
          dst_nxt   = dst_last ? '0 : dst_r + IDX_W'(1);
        end else if (!p_vld_r) begin
          cnt_nxt   = '0;
          addr_nxt  = base_r;
          state_nxt = S_STORE;
        end
      end

      S_STORE: begin
        mat_we = p_vld_r;
        if (cnt_r < len_r) begin
          p_vld_nxt  = 1'b1;
          p_addr_nxt = addr_r;
          cnt_nxt    = cnt_r + LEN_W'(1);
          addr_nxt   = addr_r + stride;
        end else if (!p_vld_r) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (state_r == S_DEC && state_nxt == S_REM) begin
      rem_start = 1'b1;
      cnt_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (state_r == S_FIN && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_rows_r  <= mlr_pkg::NUM_ROWS_RST;
      num_cols_r  <= mlr_pkg::NUM_COLS_RST;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_rows_r  <= num_rows_nxt;
      num_cols_r  <= num_cols_nxt;
      out_valid_r <= out_valid_nxt;
      p_vld_r     <= p_vld_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    len_r      <= len_nxt;
    cnt_r      <= cnt_nxt;
    base_r     <= base_nxt;
    addr_r     <= addr_nxt;
    dst_r      <= dst_nxt;
    col_mode_r <= col_mode_nxt;
    p_dst_r    <= p_dst_nxt;
    p_addr_r   <= p_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_rdata_r <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[p_dst_r] <= mat_rdata_r;
    end
    buf_rdata_r <= buf_mem[cnt_r[IDX_W-1:0]];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/matrix_line_rotator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the matrix line rotator core: directed corners and size extremes, then random traffic.
module matrix_line_rotator_core_tb;

  localparam int DIM          = mlr_pkg::MAX_DIM_DEF;
  localparam int CFG_W        = mlr_pkg::CFG_W;
  localparam int IDX_W        = mlr_pkg::IDX_FLD_W;
  localparam int AMT_W        = mlr_pkg::AMT_W;
  localparam int WORD_W       = mlr_pkg::WORD_W;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 100;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [mlr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]              cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  mlr_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  mlr_pkg::out_item_t            out_data;

  // Mirror of the element store and the size registers
  logic signed [WORD_W-1:0] mat_val [DIM*DIM];
  bit                       mat_set [DIM*DIM];
  logic [CFG_W-1:0]         rows_reg = mlr_pkg::NUM_ROWS_RST;
  logic [CFG_W-1:0]         cols_reg = mlr_pkg::NUM_COLS_RST;

  mlr_pkg::out_item_t outcome_q[$];
  int        error_count = 0;
  int        n_items     = 0;
  int        n_reads     = 0;
  int        n_rots      = 0;
  int        n_flagged   = 0;
  bit        quiet       = 1'b0;
  int        stall_mode  = 0;
  int        stall_left  = 0;
  int        burst_left  = 0;

  matrix_line_rotator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_dim(logic [CFG_W-1:0] r);
    return (r > DIM) ? DIM : int'(r);
  endfunction

  function automatic mlr_pkg::in_item_t make_op(mlr_pkg::op_t op, int r, int c, bit d,
                                                int amt, logic signed [WORD_W-1:0] wd);
    mlr_pkg::in_item_t it;
    it.opcode     = op;
    it.row_index  = IDX_W'(r);
    it.col_index  = IDX_W'(c);
    it.direction  = d;
    it.amount     = AMT_W'(amt);
    it.write_data = wd;
    return it;
  endfunction

  function automatic mlr_pkg::out_item_t apply_matrix_op(mlr_pkg::in_item_t it);
    mlr_pkg::out_item_t       res;
    int                       nr, nc, len, sh, base, stride, src, addr;
    bit                       r_ok, c_ok;
    logic signed [WORD_W-1:0] line_v [DIM];
    bit                       line_s [DIM];
    nr     = eff_dim(rows_reg);
    nc     = eff_dim(cols_reg);
    r_ok   = int'(it.row_index) < nr;
    c_ok   = int'(it.col_index) < nc;
    addr   = int'(it.row_index) * DIM + int'(it.col_index);
    res    = '0;
    len    = 0;
    base   = 0;
    stride = 1;
    case (it.opcode)
      mlr_pkg::OP_WRITE: begin
        if (r_ok && c_ok) begin
          mat_val[addr] = it.write_data;
          mat_set[addr] = 1'b1;
        end else begin
          res.status = 1'b1;
        end
      end
      mlr_pkg::OP_READ: begin
        if (r_ok && c_ok) begin
          res.read_data = mat_val[addr];
          n_reads++;
        end else begin
          res.status = 1'b1;
        end
      end
      mlr_pkg::OP_ROT_ROW: begin
        if (r_ok) begin
          len    = nc;
          base   = int'(it.row_index) * DIM;
          stride = 1;
        end else begin
          res.status = 1'b1;
        end
      end
      default: begin
        if (c_ok) begin
          len    = nr;
          base   = int'(it.col_index);
          stride = DIM;
        end else begin
          res.status = 1'b1;
        end
      end
    endcase
    if ((it.opcode == mlr_pkg::OP_ROT_ROW || it.opcode == mlr_pkg::OP_ROT_COL) &&
        !res.status) n_rots++;
    if (len > 0) begin
      sh = int'(it.amount) % len;
      if (sh != 0) begin
        for (int i = 0; i < len; i++) begin
          line_v[i] = mat_val[base + i * stride];
          line_s[i] = mat_set[base + i * stride];
        end
        for (int i = 0; i < len; i++) begin
          src = it.direction ? (i + len - sh) % len : (i + sh) % len;
          mat_val[base + i * stride] = line_v[src];
          mat_set[base + i * stride] = line_s[src];
        end
      end
    end
    if (res.status) n_flagged++;
    return res;
  endfunction

  function automatic mlr_pkg::in_item_t random_op();
    mlr_pkg::in_item_t it;
    int                nr, nc, pick;
    nr   = eff_dim(rows_reg);
    nc   = eff_dim(cols_reg);
    pick = $urandom_range(0, 9);
    if (pick < 3)      it.opcode = mlr_pkg::OP_WRITE;
    else if (pick < 6) it.opcode = mlr_pkg::OP_READ;
    else if (pick < 8) it.opcode = mlr_pkg::OP_ROT_ROW;
    else               it.opcode = mlr_pkg::OP_ROT_COL;
    it.row_index = IDX_W'((nr == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                                : $urandom_range(0, nr - 1));
    it.col_index = IDX_W'((nc == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                                : $urandom_range(0, nc - 1));
    it.direction = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      it.amount = AMT_W'($urandom_range(0, 70));
    end else if (pick == 5) begin
      case ($urandom_range(0, 2))
        0:       it.amount = '0;
        1:       it.amount = '1;
        default: it.amount = AMT_W'(DIM);
      endcase
    end else begin
      it.amount = AMT_W'($urandom_range(0, 1023));
    end
    pick = $urandom_range(0, 9);
    if (pick < 8)       it.write_data = $urandom;
    else if (pick == 8) it.write_data = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else                it.write_data = $signed($urandom_range(0, 15)) - 8;
    return it;
  endfunction

  task automatic send_item(mlr_pkg::in_item_t it);
    int gap;
    // turn a read of a never-written element into a write
    if (it.opcode == mlr_pkg::OP_READ && int'(it.row_index) < eff_dim(rows_reg) &&
        int'(it.col_index) < eff_dim(cols_reg) &&
        !mat_set[int'(it.row_index) * DIM + int'(it.col_index)])
      it.opcode = mlr_pkg::OP_WRITE;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    outcome_q.push_back(apply_matrix_op(it));
    n_items++;
  endtask

  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (outcome_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_size(int r, int c);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= mlr_pkg::REG_NUM_ROWS;
    cfg_wdata <= CFG_W'(r);
    @(posedge clk);
    cfg_index <= mlr_pkg::REG_NUM_COLS;
    cfg_wdata <= CFG_W'(c);
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_reg  = CFG_W'(r);
    cols_reg  = CFG_W'(c);
  endtask

  task automatic test_corner_values();
    send_item(make_op(mlr_pkg::OP_WRITE, 0, 0, 0, 0, 32'sh7FFF_FFFF));
    send_item(make_op(mlr_pkg::OP_WRITE, 0, 31, 1, 1023, 32'sh8000_0000));
    send_item(make_op(mlr_pkg::OP_WRITE, 31, 31, 0, 0, -32'sd1));
    send_item(make_op(mlr_pkg::OP_WRITE, 31, 0, 1, 0, 32'sd0));
    send_item(make_op(mlr_pkg::OP_WRITE, 0, 1, 0, 0, 32'sd1));
    send_item(make_op(mlr_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_READ, 0, 31, 1, 0, 0));
    send_item(make_op(mlr_pkg::OP_READ, 31, 31, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 0, 1, 0));
    send_item(make_op(mlr_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 1, 1, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 1, DIM, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 0, 1023, 0));
    send_item(make_op(mlr_pkg::OP_ROT_COL, 0, 31, 1, 33, 0));
    send_item(make_op(mlr_pkg::OP_ROT_COL, 0, 0, 0, 1023, 0));
    send_item(make_op(mlr_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_READ, 1, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_READ, 0, 1, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_READ, 0, 31, 0, 0, 0));
  endtask

  task automatic test_size_extremes();
    set_size(0, 0);
    send_item(make_op(mlr_pkg::OP_WRITE, 0, 0, 0, 0, 32'sh5A5A_A5A5));
    send_item(make_op(mlr_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 1, 3, 0));
    send_item(make_op(mlr_pkg::OP_ROT_COL, 0, 0, 0, 3, 0));
    set_size(1, 1);
    send_item(make_op(mlr_pkg::OP_WRITE, 0, 0, 0, 0, 32'sh1234_5678));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 0, 5, 0));
    send_item(make_op(mlr_pkg::OP_ROT_COL, 0, 0, 1, 1023, 0));
    send_item(make_op(mlr_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_WRITE, 0, 1, 0, 0, -32'sd7));
    send_item(make_op(mlr_pkg::OP_READ, 1, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 1, 0, 0, 1, 0));
    send_item(make_op(mlr_pkg::OP_ROT_COL, 0, 1, 1, 1, 0));
    set_size(63, 33);
    send_item(make_op(mlr_pkg::OP_WRITE, 31, 31, 0, 0, -32'sd12345));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 31, 0, 1, 3, 0));
    send_item(make_op(mlr_pkg::OP_READ, 31, 2, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_ROT_COL, 0, 2, 0, 63, 0));
    send_item(make_op(mlr_pkg::OP_READ, 0, 2, 0, 0, 0));
    set_size(5, 7);
    send_item(make_op(mlr_pkg::OP_READ, 5, 0, 0, 0, 0));
    send_item(make_op(mlr_pkg::OP_WRITE, 0, 7, 0, 0, 32'sd99));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 5, 0, 1, 2, 0));
    send_item(make_op(mlr_pkg::OP_ROT_COL, 0, 7, 0, 2, 0));
    send_item(make_op(mlr_pkg::OP_ROT_ROW, 0, 0, 0, 1023, 0));
    set_size(int'(mlr_pkg::NUM_ROWS_RST), int'(mlr_pkg::NUM_COLS_RST));
  endtask

  task automatic test_random_traffic();
    int start, phase_len, pick;
    int r, c;
    start = n_items;
    while (n_items - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        r = $urandom_range(2, 8);
        c = $urandom_range(2, 8);
      end else if (pick < 15) begin
        r = $urandom_range(9, 32);
        c = $urandom_range(9, 32);
      end else if (pick < 17) begin
        r = $urandom_range(33, 63);
        c = $urandom_range(1, 63);
      end else if (pick < 18) begin
        r = $urandom_range(0, 1);
        c = $urandom_range(0, 8);
      end else begin
        r = $urandom_range(1, 8);
        c = $urandom_range(0, 1);
      end
      set_size(r, c);
      quiet      <= ($urandom_range(0, 3) == 0);
      stall_mode <= $urandom_range(0, 2);
      phase_len   = $urandom_range(80, 220);
      for (int k = 0; k < phase_len && n_items - start < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) == 0) wait_idle();
        send_item(random_op());
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    mlr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result transaction: read_data %0d status %0d",
               out_data.read_data, out_data.status);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %0d, actual %0d",
                 want.read_data, out_data.read_data);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : stall_gen
    if (!rst_n || quiet || stall_mode == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !out_stall;
      stall_left <= out_stall ? $urandom_range(0, 6)
                              : (stall_mode == 1 ? $urandom_range(0, 2) : $urandom_range(2, 12));
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_size_extremes();
    test_random_traffic();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d transactions: %0d reads checked, %0d line rotations, %0d out of range,",
             n_items, n_reads, n_rots, n_flagged);
    $display("across matrix sizes from 0 to 63 with random sender gaps and receiver stalls.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
